// ===== design/bmma_pkg.sv =====
`timescale 1ns / 1ps

package bmma_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int MAX_READ_DEF  = 64;

    localparam int LEN_WIDTH = 7;
    localparam int MIN_READ  = 3;
    localparam int CLAMP_MAX = 127;

    localparam logic [7:0] BTN_IDLE  = 8'h80;
    localparam logic [7:0] SYNC_BIT  = 8'h80;
    localparam logic [7:0] PAD_BYTE  = 8'h00;

    localparam logic KIND_NIBBLE = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_MOTION  = 2'd0;
    localparam t_cmd CMD_READ    = 2'd1;
    localparam t_cmd CMD_OPEN    = 2'd2;
    localparam t_cmd CMD_RELEASE = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_LEN  = 2'd1;
    localparam t_status ST_NO_DATA  = 2'd2;
    localparam t_status ST_BUSY     = 2'd3;

    // One decoded request as it travels from the front end to the back end.
    typedef struct packed {
        t_cmd                  cmd;
        logic [7:0]            dx;
        logic [7:0]            dy;
        logic [2:0]            btn;
        logic [LEN_WIDTH-1:0]  len;
    } t_op;

endpackage

// ===== design/bmma_front.sv =====
`timescale 1ns / 1ps

module bmma_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  bmma_pkg::t_cmd                      i_cmd,
    input  logic [7:0]                          i_port_byte_a,
    input  logic [7:0]                          i_port_byte_b,
    input  logic [7:0]                          i_port_byte_c,
    input  logic [7:0]                          i_port_byte_d,
    input  logic [bmma_pkg::LEN_WIDTH-1:0]      i_read_len,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    output logic                                o_op_valid,
    output bmma_pkg::t_op                       o_op,
    input  logic                                i_pop
);

    logic            r_mouse_kind;
    bmma_pkg::t_op   r_queue [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    bmma_pkg::t_op   w_op;
    logic            w_push;
    logic            w_pop;

    // Decode the raw port bytes according to the selected port layout.
    always_comb begin
        w_op     = '0;
        w_op.cmd = i_cmd;
        w_op.len = i_read_len;
        if (r_mouse_kind == bmma_pkg::KIND_NIBBLE) begin
            w_op.dx  = {i_port_byte_b[3:0], i_port_byte_a[3:0]};
            w_op.dy  = {i_port_byte_d[3:0], i_port_byte_c[3:0]};
            w_op.btn = i_port_byte_d[7:5];
        end else begin
            w_op.dx  = i_port_byte_a;
            w_op.dy  = i_port_byte_b;
            w_op.btn = ~i_port_byte_c[2:0];
        end
    end

    assign o_ready    = (r_count != 2'd2);
    assign w_push     = i_valid && o_ready;
    assign w_pop      = i_pop && (r_count != 2'd0);
    assign o_op_valid = (r_count != 2'd0);
    assign o_op       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_kind <= bmma_pkg::KIND_NIBBLE;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_count      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mouse_kind <= i_cfg_data;
            end
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_op;
        end
    end

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptrs_track : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/bmma_back.sv =====
`timescale 1ns / 1ps

module bmma_back #(
    parameter int ACC_WIDTH = bmma_pkg::ACC_WIDTH_DEF,
    parameter int MAX_READ  = bmma_pkg::MAX_READ_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    input  bmma_pkg::t_op         i_op,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_byte,
    output bmma_pkg::t_status     o_status,
    output logic                  o_last
);

    localparam int LW = bmma_pkg::LEN_WIDTH;
    localparam logic signed [ACC_WIDTH-1:0] CLAMP_HI = ACC_WIDTH'(bmma_pkg::CLAMP_MAX);
    localparam logic signed [ACC_WIDTH-1:0] CLAMP_LO = -CLAMP_HI;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic {S_IDLE, S_EMIT} t_state;

    t_state                          r_state, n_state;
    logic signed [ACC_WIDTH-1:0]     r_accum_x, n_accum_x;
    logic signed [ACC_WIDTH-1:0]     r_accum_y, n_accum_y;
    logic [7:0]                      r_cur_btn, n_cur_btn;
    logic [7:0]                      r_lat_btn, n_lat_btn;
    logic                            r_data_ready, n_data_ready;
    logic                            r_opened, n_opened;
    logic [7:0]                      r_b1, n_b1;
    logic [7:0]                      r_b2, n_b2;
    logic [LW-1:0]                   r_idx, n_idx;
    logic [LW-1:0]                   r_len, n_len;
    logic                            r_o_valid, n_o_valid;
    logic [7:0]                      r_o_byte, n_o_byte;
    bmma_pkg::t_status               r_o_status, n_o_status;
    logic                            r_o_last, n_o_last;

    logic                            w_out_free;
    logic signed [ACC_WIDTH:0]       w_sum_x, w_sum_y;
    logic signed [ACC_WIDTH-1:0]     w_sat_x, w_sat_y;
    logic signed [ACC_WIDTH-1:0]     w_clamp_x, w_clamp_y;
    logic                            w_bad_len;

    assign w_sum_x = {r_accum_x[ACC_WIDTH-1], r_accum_x}
                   + {{(ACC_WIDTH-7){i_op.dx[7]}}, i_op.dx};
    assign w_sum_y = {r_accum_y[ACC_WIDTH-1], r_accum_y}
                   + {{(ACC_WIDTH-7){i_op.dy[7]}}, i_op.dy};

    always_comb begin
        if (w_sum_x[ACC_WIDTH] != w_sum_x[ACC_WIDTH-1]) begin
            w_sat_x = w_sum_x[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sat_x = w_sum_x[ACC_WIDTH-1:0];
        end
        if (w_sum_y[ACC_WIDTH] != w_sum_y[ACC_WIDTH-1]) begin
            w_sat_y = w_sum_y[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sat_y = w_sum_y[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        if (r_accum_x > CLAMP_HI) begin
            w_clamp_x = CLAMP_HI;
        end else if (r_accum_x < CLAMP_LO) begin
            w_clamp_x = CLAMP_LO;
        end else begin
            w_clamp_x = r_accum_x;
        end
        if (r_accum_y > CLAMP_HI) begin
            w_clamp_y = CLAMP_HI;
        end else if (r_accum_y < CLAMP_LO) begin
            w_clamp_y = CLAMP_LO;
        end else begin
            w_clamp_y = r_accum_y;
        end
    end

    assign w_bad_len = (i_op.len < LW'(bmma_pkg::MIN_READ)) || (i_op.len > LW'(MAX_READ));
    assign w_out_free = !r_o_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && i_op_valid && w_out_free;

    always_comb begin
        n_state      = r_state;
        n_accum_x    = r_accum_x;
        n_accum_y    = r_accum_y;
        n_cur_btn    = r_cur_btn;
        n_lat_btn    = r_lat_btn;
        n_data_ready = r_data_ready;
        n_opened     = r_opened;
        n_b1         = r_b1;
        n_b2         = r_b2;
        n_idx        = r_idx;
        n_len        = r_len;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_byte     = r_o_byte;
        n_o_status   = r_o_status;
        n_o_last     = r_o_last;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_op.cmd)
                        bmma_pkg::CMD_MOTION: begin
                            n_cur_btn    = {5'd0, i_op.btn};
                            n_lat_btn    = r_lat_btn | {5'd0, i_op.btn};
                            n_accum_x    = w_sat_x;
                            n_accum_y    = w_sat_y;
                            n_data_ready = 1'b1;
                        end
                        bmma_pkg::CMD_READ: begin
                            n_o_valid = 1'b1;
                            n_o_byte  = bmma_pkg::PAD_BYTE;
                            n_o_last  = 1'b1;
                            if (w_bad_len) begin
                                n_o_status = bmma_pkg::ST_BAD_LEN;
                            end else if (!r_data_ready) begin
                                n_o_status = bmma_pkg::ST_NO_DATA;
                            end else begin
                                n_o_status   = bmma_pkg::ST_OK;
                                n_o_byte     = r_lat_btn | bmma_pkg::SYNC_BIT;
                                n_o_last     = 1'b0;
                                n_b1         = w_clamp_x[7:0];
                                n_b2         = 8'd0 - w_clamp_y[7:0];
                                n_idx        = LW'(1);
                                n_len        = i_op.len;
                                n_state      = S_EMIT;
                                n_accum_x    = '0;
                                n_accum_y    = '0;
                                n_lat_btn    = r_cur_btn;
                                n_data_ready = 1'b0;
                            end
                        end
                        bmma_pkg::CMD_OPEN: begin
                            n_o_valid = 1'b1;
                            n_o_byte  = bmma_pkg::PAD_BYTE;
                            n_o_last  = 1'b1;
                            if (r_opened) begin
                                n_o_status = bmma_pkg::ST_BUSY;
                            end else begin
                                n_o_status   = bmma_pkg::ST_OK;
                                n_opened     = 1'b1;
                                n_data_ready = 1'b0;
                                n_accum_x    = '0;
                                n_accum_y    = '0;
                                n_cur_btn    = bmma_pkg::BTN_IDLE;
                                n_lat_btn    = bmma_pkg::BTN_IDLE;
                            end
                        end
                        default: begin
                            n_o_valid    = 1'b1;
                            n_o_byte     = bmma_pkg::PAD_BYTE;
                            n_o_status   = bmma_pkg::ST_OK;
                            n_o_last     = 1'b1;
                            n_opened     = 1'b0;
                            n_data_ready = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = bmma_pkg::ST_OK;
                    n_o_last   = (r_idx == r_len - LW'(1));
                    n_idx      = r_idx + LW'(1);
                    if (r_idx == LW'(1)) begin
                        n_o_byte = r_b1;
                    end else if (r_idx == LW'(2)) begin
                        n_o_byte = r_b2;
                    end else begin
                        n_o_byte = bmma_pkg::PAD_BYTE;
                    end
                    if (r_idx == r_len - LW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_accum_x    <= '0;
            r_accum_y    <= '0;
            r_cur_btn    <= bmma_pkg::BTN_IDLE;
            r_lat_btn    <= bmma_pkg::BTN_IDLE;
            r_data_ready <= 1'b0;
            r_opened     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_accum_x    <= n_accum_x;
            r_accum_y    <= n_accum_y;
            r_cur_btn    <= n_cur_btn;
            r_lat_btn    <= n_lat_btn;
            r_data_ready <= n_data_ready;
            r_opened     <= n_opened;
            r_o_valid    <= n_o_valid;
        end
        r_b1       <= n_b1;
        r_b2       <= n_b2;
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_o_byte   <= n_o_byte;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_valid    = r_o_valid;
    assign o_out_byte = r_o_byte;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

`ifndef SYNTHESIS
    a_emit_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_data_ready && r_accum_x == '0 && r_accum_y == '0))
        else $error("totals not cleared during packet output");

    a_error_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != bmma_pkg::ST_OK) |-> (r_o_last && r_o_byte == '0))
        else $error("error request result not final");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx != '0 && r_idx < r_len))
        else $error("packet byte index out of range");

    a_no_pop_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_pop)
        else $error("queue popped during packet output");
`endif

endmodule

// ===== design/bus_mouse_motion_accumulator_top.sv =====
`timescale 1ns / 1ps
// A request is queued on acceptance and popped when the unit is idle and the output register is
// free; any result is registered on the pop. Motion, open and release finish on their pop; a good
// read sends read_len packet bytes, one packet byte per cycle while the output register is free.
// A two-entry queue lets new requests be taken while a packet is still being sent.
// Reset is synchronous and active low; it empties the queue and restores all totals and flags.

module bus_mouse_motion_accumulator_top #(
    parameter int ACC_WIDTH = bmma_pkg::ACC_WIDTH_DEF,
    parameter int MAX_READ  = bmma_pkg::MAX_READ_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [7:0]                      i_port_byte_a,
    input  logic [7:0]                      i_port_byte_b,
    input  logic [7:0]                      i_port_byte_c,
    input  logic [7:0]                      i_port_byte_d,
    input  logic [6:0]                      i_read_len,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_out_byte,
    output logic [1:0]                      o_status,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data
);

    logic           w_op_valid;
    bmma_pkg::t_op  w_op;
    logic           w_pop;

    bmma_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_port_byte_a (i_port_byte_a),
        .i_port_byte_b (i_port_byte_b),
        .i_port_byte_c (i_port_byte_c),
        .i_port_byte_d (i_port_byte_d),
        .i_read_len    (i_read_len),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_op_valid    (w_op_valid),
        .o_op          (w_op),
        .i_pop         (w_pop)
    );

    bmma_back #(
        .ACC_WIDTH (ACC_WIDTH),
        .MAX_READ  (MAX_READ)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule
